### sv/hks_pkg.sv
// Package for the heapsort key/tag block: field widths, item structs
// and the sequencer state type. No dependencies.
`default_nettype none

package hks_pkg;

    localparam int KEY_BITS = 32;
    localparam int TAG_BITS = 14;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [KEY_BITS-1:0] sorted_key;
        logic [TAG_BITS-1:0] sorted_tag;
        logic                end_of_set;
        logic                overflow;
    } t_out_item;

    // one stored entry
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_pair;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_TOP,
        ST_GET_TOP,
        ST_SIFT_CHK,
        ST_SIFT_CMP,
        ST_SINK_END,
        ST_EX_RD,
        ST_EX_WR,
        ST_OUT_RD,
        ST_OUT_LD
    } t_state;

endpackage

`default_nettype wire

### sv/heapsort_key_tag.sv
// Load phase: one item accepted per cycle, no result until the closing item.
// Sort of n pairs: heap build from (n-2)/2 down to 0, then n-1 extractions; every sift
// level is a child read (ST_SIFT_CHK), then compare and write back (ST_SIFT_CMP) on the
// pair memory, plus setup states per sift (ST_RD_TOP and ST_GET_TOP, or ST_EX_RD and ST_EX_WR, then ST_SINK_END).
// Output: per sorted pair one memory read (ST_OUT_RD), then one output register load (ST_OUT_LD).
// Reset (synchronous, active low) clears the set count, overflow flag and output valid.
`default_nettype none

module heapsort_key_tag
    import hks_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = CW + 1;

    // pair memory, one write and two read ports, registered reads
    t_pair mem [DEPTH];
    t_pair r_rd_a, r_rd_b;

    logic          w_we, w_rea, w_reb;
    logic [AW-1:0] w_wa, w_ra_a, w_ra_b;
    t_pair         w_wd;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_lim, n_lim;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_node, n_node;
    logic [AW-1:0] r_k, n_k;
    logic          r_build, n_build;
    t_pair         r_hold, n_hold;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_out, n_out;

    logic          w_accept;
    logic [CW-1:0] w_cnt_new;
    logic [NW-1:0] w_kid, w_kid1;
    logic          w_use_b;
    t_pair         w_child;
    logic [NW-1:0] w_c;
    logic          w_eos;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_rea) begin
            r_rd_a <= mem[w_ra_a];
        end
        if (w_reb) begin
            r_rd_b <= mem[w_ra_b];
        end
    end

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_cnt_new = (r_count < CW'(DEPTH)) ? r_count + CW'(1) : r_count;
    assign w_kid     = NW'({r_node, 1'b1});
    assign w_kid1    = w_kid + NW'(1);
    assign w_use_b   = (w_kid1 < NW'(r_lim)) && (r_rd_a.key < r_rd_b.key);
    assign w_child   = w_use_b ? r_rd_b : r_rd_a;
    assign w_c       = w_use_b ? w_kid1 : w_kid;
    assign w_eos     = (CW'(r_k) + CW'(1)) == r_count;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_lim      = r_lim;
        n_idx      = r_idx;
        n_node     = r_node;
        n_k        = r_k;
        n_build    = r_build;
        n_hold     = r_hold;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_out      = r_out;
        w_we       = 1'b0;
        w_wa       = r_node;
        w_wd       = r_hold;
        w_rea      = 1'b0;
        w_ra_a     = r_idx;
        w_reb      = 1'b0;
        w_ra_b     = r_idx;
        o_in_ready = 1'b0;

        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    if (r_count < CW'(DEPTH)) begin
                        w_we    = 1'b1;
                        w_wa    = r_count[AW-1:0];
                        w_wd    = '{key: i_in_item.key, tag: i_in_item.tag};
                        n_count = w_cnt_new;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_item.last) begin
                        if (w_cnt_new < CW'(2)) begin
                            n_k     = '0;
                            n_state = ST_OUT_RD;
                        end else begin
                            n_lim   = w_cnt_new;
                            n_idx   = AW'((w_cnt_new >> 1) - CW'(1));
                            n_build = 1'b1;
                            n_state = ST_RD_TOP;
                        end
                    end
                end
            end
            ST_RD_TOP: begin
                w_rea   = 1'b1;
                w_ra_a  = r_idx;
                n_state = ST_GET_TOP;
            end
            ST_GET_TOP: begin
                n_hold  = r_rd_a;
                n_node  = r_idx;
                n_state = ST_SIFT_CHK;
            end
            ST_SIFT_CHK: begin
                if (w_kid >= NW'(r_lim)) begin
                    // leaf reached: drop the held pair into the hole
                    w_we    = 1'b1;
                    n_state = ST_SINK_END;
                end else begin
                    w_rea   = 1'b1;
                    w_ra_a  = w_kid[AW-1:0];
                    w_reb   = 1'b1;
                    w_ra_b  = (w_kid1 < NW'(r_lim)) ? w_kid1[AW-1:0] : w_kid[AW-1:0];
                    n_state = ST_SIFT_CMP;
                end
            end
            ST_SIFT_CMP: begin
                w_we = 1'b1;
                if (r_hold.key < w_child.key) begin
                    // child moves up, hole moves down
                    w_wd    = w_child;
                    n_node  = w_c[AW-1:0];
                    n_state = ST_SIFT_CHK;
                end else begin
                    n_state = ST_SINK_END;
                end
            end
            ST_SINK_END: begin
                if (r_build) begin
                    if (r_idx == '0) begin
                        n_build = 1'b0;
                        n_idx   = AW'(r_count - CW'(1));
                        n_state = ST_EX_RD;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = ST_RD_TOP;
                    end
                end else if (r_idx == AW'(1)) begin
                    n_k     = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_idx   = r_idx - AW'(1);
                    n_state = ST_EX_RD;
                end
            end
            ST_EX_RD: begin
                w_rea   = 1'b1;
                w_ra_a  = '0;
                w_reb   = 1'b1;
                w_ra_b  = r_idx;
                n_state = ST_EX_WR;
            end
            ST_EX_WR: begin
                // root goes to the end, old last entry sifts from the root
                w_we    = 1'b1;
                w_wa    = r_idx;
                w_wd    = r_rd_a;
                n_hold  = r_rd_b;
                n_node  = '0;
                n_lim   = CW'(r_idx);
                n_state = ST_SIFT_CHK;
            end
            ST_OUT_RD: begin
                w_rea   = 1'b1;
                w_ra_a  = r_k;
                n_state = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid         = 1'b1;
                    n_out.sorted_key = r_rd_a.key;
                    n_out.sorted_tag = r_rd_a.tag;
                    n_out.end_of_set = w_eos;
                    n_out.overflow   = r_ovf;
                    if (w_eos) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_build  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
            r_build  <= n_build;
        end
        r_lim  <= n_lim;
        r_idx  <= n_idx;
        r_node <= n_node;
        r_k    <= n_k;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("set count above depth");

    a_sift_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIFT_CHK) |-> (CW'(r_node) < r_lim && r_lim <= r_count))
        else $error("sift node outside heap");

    a_extract_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EX_RD) |-> (r_idx != '0 && !r_build))
        else $error("extraction at root");

    a_set_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT_LD && (!r_ovalid || i_out_ready) && w_eos)
        |=> (r_count == '0 && !r_ovf && r_state == ST_LOAD))
        else $error("set not cleared after last pair");

endmodule

`default_nettype wire

### tb/sv/heapsort_key_tag_test.sv
// Self-checking testbench for heapsort_key_tag: loads key/tag sets, predicts the
// ascending key order output of each set and checks every result item field by field.
// Depends on hks_pkg and the heapsort_key_tag RTL.
module heapsort_key_tag_test
    import hks_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_DEPTH = 64;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // idle chances in percent, and the receiver hold-off in cycles
    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned hold_len = 0;

    // predictor state: pairs of the set being loaded
    t_pair       load_pairs[SET_DEPTH];
    int unsigned load_cnt = 0;
    logic        load_dropped = 1'b0;

    t_out_item   sorted_pairs_q[$];
    int unsigned mismatch_cnt = 0;

    heapsort_key_tag #(
        .DEPTH(SET_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void swap_pairs(int unsigned a, int unsigned b);
        t_pair tmp;
        tmp = load_pairs[a];
        load_pairs[a] = load_pairs[b];
        load_pairs[b] = tmp;
    endfunction

    function automatic void sift_down(int unsigned top, int unsigned lim);
        int unsigned node;
        int unsigned kid;
        bit          done;
        node = top;
        done = 1'b0;
        while (!done && 2 * node + 1 < lim) begin
            kid = 2 * node + 1;
            if (kid + 1 < lim && load_pairs[kid].key < load_pairs[kid + 1].key)
                kid++;
            if (load_pairs[node].key < load_pairs[kid].key) begin
                swap_pairs(kid, node);
                node = kid;
            end else begin
                done = 1'b1;
            end
        end
    endfunction

    // heapsort the loaded set and queue its sorted pairs
    function automatic void sort_and_queue_set();
        int unsigned n;
        t_out_item   res;
        n = load_cnt;
        if (n >= 2) begin
            for (int i = (n - 2) / 2; i >= 0; i--)
                sift_down(i, n);
            for (int i = n - 1; i > 0; i--) begin
                swap_pairs(i, 0);
                sift_down(0, i);
            end
        end
        for (int k = 0; k < n; k++) begin
            res.sorted_key = load_pairs[k].key;
            res.sorted_tag = load_pairs[k].tag;
            res.end_of_set = (k + 1 == n);
            res.overflow   = load_dropped;
            sorted_pairs_q.push_back(res);
        end
        load_cnt = 0;
        load_dropped = 1'b0;
    endfunction

    function automatic void record_item(t_in_item it);
        if (load_cnt < SET_DEPTH) begin
            load_pairs[load_cnt].key = it.key;
            load_pairs[load_cnt].tag = it.tag;
            load_cnt++;
        end else begin
            load_dropped = 1'b1;
        end
        if (it.last)
            sort_and_queue_set();
    endfunction

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_pair(logic [KEY_BITS-1:0] key, logic [TAG_BITS-1:0] tag, logic last);
        t_in_item it;
        it.key  = key;
        it.tag  = tag;
        it.last = last;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        record_item(it);
    endtask

    task automatic send_set(int unsigned n, int unsigned style);
        logic [KEY_BITS-1:0] key;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: key = $urandom;
                1: key = $urandom_range(3);      // many equal keys
                default: begin
                    case ($urandom_range(2))
                        0: key = '0;
                        1: key = '1;
                        default: key = $urandom;
                    endcase
                end
            endcase
            send_pair(key, TAG_BITS'($urandom_range(16383)), i == n - 1);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sorted_pairs_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(string what, t_out_item want, t_out_item got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t %s: key %h/%h tag %h/%h eos %b/%b ovf %b/%b (exp/got)",
                     $realtime, what, want.sorted_key, got.sorted_key,
                     want.sorted_tag, got.sorted_tag, want.end_of_set, got.end_of_set,
                     want.overflow, got.overflow);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sorted_pairs_q.size() == 0) begin
                note_mismatch("unexpected result", '0, o_out_item);
            end else begin
                want = sorted_pairs_q.pop_front();
                if (o_out_item.sorted_key !== want.sorted_key
                        || o_out_item.sorted_tag !== want.sorted_tag
                        || o_out_item.end_of_set !== want.end_of_set
                        || o_out_item.overflow !== want.overflow)
                    note_mismatch("mismatch", want, o_out_item);
            end
        end
    end

    // receiver: long hold-off when requested, random stalls otherwise
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                i_out_ready <= 1'b0;
                hold_len--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    task automatic test_directed();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_pair('1, 14'h3fff, 1'b1);                  // single pair set
        send_pair('0, 14'h0000, 1'b0);
        send_pair('1, 14'h0001, 1'b1);
        for (int i = 1; i <= 4; i++)                    // all keys equal
            send_pair(32'd5, TAG_BITS'(i), i == 4);
        send_pair(32'hffff_ffff, 14'h0010, 1'b0);
        send_pair(32'h0000_0000, 14'h3fff, 1'b0);
        send_pair(32'h8000_0000, 14'h2aaa, 1'b0);
        send_pair(32'hffff_ffff, 14'h1555, 1'b0);
        send_pair(32'h0000_0000, 14'h0000, 1'b0);
        send_pair(32'h0000_0001, 14'h0123, 1'b1);
        for (int i = 0; i < 6; i++)                     // descending
            send_pair(32'h0001_0000 * (6 - i), 14'h0100 + TAG_BITS'(i), i == 5);
        for (int i = 0; i < 5; i++)                     // ascending
            send_pair(32'h7fff_0000 + i, 14'h2000 + TAG_BITS'(i), i == 4);
    endtask

    task automatic test_overflow();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        // closing item is the first one past a full store and gets dropped
        for (int i = 0; i <= SET_DEPTH; i++)
            send_pair($urandom, TAG_BITS'(i), i == SET_DEPTH);
    endtask

    task automatic test_backpressure();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_len      = 400;
        for (int s = 0; s < 3; s++)
            send_set(8, s);
        drain_results();
        send_set(6, 1);
    endtask

    task automatic test_random_traffic(int unsigned in_pct, int unsigned out_pct,
                                       int unsigned n_items);
        int unsigned sent;
        int unsigned r;
        int unsigned n;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 85)
                n = $urandom_range(1, 10);
            else if (r < 95)
                n = $urandom_range(11, 30);
            else
                n = $urandom_range(60, 68);
            send_set(n, $urandom_range(2));
            sent += n;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_overflow();
        test_backpressure();
        test_random_traffic(0, 0, 55);
        test_random_traffic(68, 0, 55);
        test_random_traffic(0, 68, 55);
        test_random_traffic(16, 16, 55);
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS heapsort_key_tag");
        else
            $display("FAIL heapsort_key_tag");
        $finish;
    end

    initial begin
        #500000;
        $display("FAIL heapsort_key_tag");
        $finish;
    end

endmodule
